[rtl/dual_wheel_odometry_core_defines.svh]
// Assertion macros for the odometry core checker
`ifndef DUAL_WHEEL_ODOMETRY_CORE_DEFINES_SVH
`define DUAL_WHEEL_ODOMETRY_CORE_DEFINES_SVH

// Clocked check, muted while reset is held
`define DWO_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry core check failed");

// Clocked check that also runs through reset
`define DWO_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("odometry core reset check failed");

`endif

[rtl/dwo_pkg.sv]
// Types and constants shared by the odometry core modules
package dwo_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [9:0]  TickPeriodRst   = 10'd50;
  localparam logic [13:0] SamplePeriodRst = 14'd100;
  localparam logic [11:0] MmPerRevRst     = 12'd200;
  localparam logic [15:0] CountsPerRevRst = 16'd4000;

  localparam logic [9:0]  MsPerSec     = 10'd1000;
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  localparam int unsigned DvdW     = 54;
  localparam int unsigned DsrW     = 30;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned DivSteps = DvdW / 2;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_STATUS = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CLEAR,
    OP_STATUS,
    OP_REPORT
  } op_e;

  typedef enum logic [2:0] {
    CFG_TICK_PERIOD   = 3'd0,
    CFG_SAMPLE_PERIOD = 3'd1,
    CFG_LEFT_MM       = 3'd2,
    CFG_RIGHT_MM      = 3'd3,
    CFG_COUNTS        = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DWAIT,
    ST_CMUL,
    ST_CSTORE,
    ST_OUT
  } seq_e;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [15:0] delta_left;
    logic signed [15:0] delta_right;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] count_left;
    logic signed [31:0] count_right;
    logic signed [31:0] distance_mm_left;
    logic signed [31:0] distance_mm_right;
    logic signed [15:0] distance_cm_left;
    logic signed [15:0] distance_cm_right;
    logic signed [31:0] speed_mm_s_left;
    logic signed [31:0] speed_mm_s_right;
    logic signed [15:0] speed_cm_s_left;
    logic signed [15:0] speed_cm_s_right;
    logic               speed_updated;
  } out_word_t;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] delta_left;
    logic signed [15:0] delta_right;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  tick_period_ms;
    logic [13:0] sample_period_ms;
    logic [11:0] left_mm_per_rev;
    logic [11:0] right_mm_per_rev;
    logic [15:0] counts_per_rev;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/dwo_front.sv]
// Input side: classifies request words and queues them for the back end
module dwo_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dwo_pkg::in_word_t  in_i,
  output logic               full_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output dwo_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  dwo_pkg::cmd_t   mem_q [QueueDepth];
  dwo_pkg::cmd_t   cmd_new;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    cmd_new.delta_left  = in_i.delta_left;
    cmd_new.delta_right = in_i.delta_right;
    unique case (in_i.req_type)
      dwo_pkg::REQ_TICK:   cmd_new.op = dwo_pkg::OP_TICK;
      dwo_pkg::REQ_CLEAR:  cmd_new.op = dwo_pkg::OP_CLEAR;
      dwo_pkg::REQ_STATUS: cmd_new.op = dwo_pkg::OP_STATUS;
      default:             cmd_new.op = dwo_pkg::OP_REPORT;
    endcase
  end

  assign full_o      = (cnt_q == DepthCnt);
  assign cmd_valid_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

[rtl/dwo_div.sv]
// Unsigned restoring divider, two quotient bits per cycle, low quotient bits kept
module dwo_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dwo_pkg::div_req_t req_i,
  output dwo_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DvdW = dwo_pkg::DvdW;
  localparam int unsigned DsrW = dwo_pkg::DsrW;
  localparam int unsigned QuoW = dwo_pkg::QuoW;
  localparam int unsigned CntW = dwo_pkg::DivCntW;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DsrW-1:0] dsr_q, rem_q;
  logic [QuoW-1:0] quo_q;

  logic [DsrW:0]   r1, r2;
  logic [DsrW-1:0] rem1, rem2;
  logic            b1, b2;
  logic            zero_dsr;

  assign zero_dsr = (req_i.divisor == '0);

  always_comb begin
    r1   = {rem_q, dvd_q[DvdW-1]};
    b1   = (r1 >= {1'b0, dsr_q});
    rem1 = b1 ? DsrW'(r1 - {1'b0, dsr_q}) : r1[DsrW-1:0];
    r2   = {rem1, dvd_q[DvdW-2]};
    b2   = (r2 >= {1'b0, dsr_q});
    rem2 = b2 ? DsrW'(r2 - {1'b0, dsr_q}) : r2[DsrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= !zero_dsr;
      done_q <= zero_dsr;
      cnt_q  <= CntW'(dwo_pkg::DivSteps - 1);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CntW'(1);
      busy_q <= (cnt_q != '0);
      done_q <= (cnt_q == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-3:0], 2'b00};
      rem_q <= rem2;
      quo_q <= {quo_q[QuoW-3:0], b1, b2};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/dwo_back.sv]
// Back end: odometry state, shared multiplier sequencing and result register
module dwo_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dwo_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  dwo_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output dwo_pkg::div_req_t  div_req_o,
  input  dwo_pkg::div_rsp_t  div_rsp_i,
  input  logic               pop_i,
  output logic               empty_o,
  output dwo_pkg::out_word_t result_o
);

  dwo_pkg::seq_e state_q, state_d;

  logic [31:0] total_l_q, total_r_q, win_l_q, win_r_q, speed_l_q, speed_r_q;
  logic [15:0] elapsed_q;
  logic        flag_q, flag_out_q;
  logic [31:0] diff_l_q, diff_r_q, dist_l_q, dist_r_q;
  logic [15:0] cm_q [4];
  logic [63:0] product_q;
  logic        sign_q;
  logic [1:0]  job_q;
  logic [21:0] kl_q, kr_q;
  logic [29:0] dsp_q;
  logic        out_valid_q;
  dwo_pkg::out_word_t result_q;

  logic        item_ld, mul_en, div_start, job_wr, cm_wr, out_ld, slot_free;
  logic [31:0] tot_l_n, tot_r_n, mul_x, mul_a, mul_b, quo_s;
  logic [15:0] el_sum, cm_raw, cm_s;
  logic        close_n;

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dwo_pkg::ST_IDLE:   if (cmd_valid_i) state_d = dwo_pkg::ST_MUL;
      dwo_pkg::ST_MUL:    state_d = dwo_pkg::ST_DIV;
      dwo_pkg::ST_DIV:    state_d = dwo_pkg::ST_DWAIT;
      dwo_pkg::ST_DWAIT: begin
        if (div_rsp_i.done) begin
          state_d = (job_q == 2'd3) ? dwo_pkg::ST_CMUL : dwo_pkg::ST_MUL;
        end
      end
      dwo_pkg::ST_CMUL:   state_d = dwo_pkg::ST_CSTORE;
      dwo_pkg::ST_CSTORE: begin
        state_d = (job_q == 2'd3) ? dwo_pkg::ST_OUT : dwo_pkg::ST_CMUL;
      end
      dwo_pkg::ST_OUT:    if (slot_free) state_d = dwo_pkg::ST_IDLE;
      default:            state_d = dwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ld   = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    job_wr    = 1'b0;
    cm_wr     = 1'b0;
    out_ld    = 1'b0;
    unique case (state_q)
      dwo_pkg::ST_IDLE:   item_ld   = cmd_valid_i;
      dwo_pkg::ST_MUL:    mul_en    = 1'b1;
      dwo_pkg::ST_DIV:    div_start = 1'b1;
      dwo_pkg::ST_DWAIT:  job_wr    = div_rsp_i.done;
      dwo_pkg::ST_CMUL:   mul_en    = 1'b1;
      dwo_pkg::ST_CSTORE: cm_wr     = 1'b1;
      dwo_pkg::ST_OUT:    out_ld    = slot_free;
      default:            item_ld   = 1'b0;
    endcase
  end

  assign cmd_pop_o = item_ld;

  always_comb begin
    tot_l_n = total_l_q - {{14{cmd_i.delta_left[15]}}, cmd_i.delta_left, 2'b00};
    tot_r_n = total_r_q + {{16{cmd_i.delta_right[15]}}, cmd_i.delta_right};
    el_sum  = elapsed_q + {6'b0, cfg_i.tick_period_ms};
    close_n = (cmd_i.op == dwo_pkg::OP_TICK) && (el_sum >= {2'b0, cfg_i.sample_period_ms});
  end

  // select operands of the shared multiplier
  always_comb begin
    if (state_q == dwo_pkg::ST_CMUL) begin
      mul_b = dwo_pkg::Recip10;
      unique case (job_q)
        2'd0:    mul_x = dist_l_q;
        2'd1:    mul_x = dist_r_q;
        2'd2:    mul_x = speed_l_q;
        default: mul_x = speed_r_q;
      endcase
    end else begin
      unique case (job_q)
        2'd0:    begin mul_x = diff_l_q;  mul_b = {10'b0, kl_q}; end
        2'd1:    begin mul_x = diff_r_q;  mul_b = {10'b0, kr_q}; end
        2'd2:    begin mul_x = total_l_q; mul_b = {20'b0, cfg_i.left_mm_per_rev}; end
        default: begin mul_x = total_r_q; mul_b = {20'b0, cfg_i.right_mm_per_rev}; end
      endcase
    end
    mul_a = mul_x[31] ? (~mul_x + 32'd1) : mul_x;
  end

  assign div_req_o.start    = div_start;
  assign div_req_o.dividend = product_q[dwo_pkg::DvdW-1:0];
  assign div_req_o.divisor  = job_q[1] ? {14'b0, cfg_i.counts_per_rev} : dsp_q;

  assign quo_s  = sign_q ? (32'd0 - div_rsp_i.quotient) : div_rsp_i.quotient;
  assign cm_raw = product_q[dwo_pkg::Recip10Shift +: 16];
  assign cm_s   = sign_q ? (16'd0 - cm_raw) : cm_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dwo_pkg::ST_IDLE;
      total_l_q   <= '0;
      total_r_q   <= '0;
      win_l_q     <= '0;
      win_r_q     <= '0;
      speed_l_q   <= '0;
      speed_r_q   <= '0;
      elapsed_q   <= '0;
      flag_q      <= 1'b0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (item_ld) begin
        job_q <= close_n ? 2'd0 : 2'd2;
        unique case (cmd_i.op)
          dwo_pkg::OP_TICK: begin
            total_l_q <= tot_l_n;
            total_r_q <= tot_r_n;
            if (close_n) begin
              elapsed_q <= '0;
              win_l_q   <= tot_l_n;
              win_r_q   <= tot_r_n;
              flag_q    <= 1'b1;
            end else begin
              elapsed_q <= el_sum;
            end
          end
          dwo_pkg::OP_CLEAR: begin
            total_l_q <= '0;
            total_r_q <= '0;
            win_l_q   <= '0;
            win_r_q   <= '0;
            speed_l_q <= '0;
            speed_r_q <= '0;
            elapsed_q <= '0;
          end
          dwo_pkg::OP_STATUS: flag_q <= 1'b0;
          default:            flag_q <= flag_q;
        endcase
      end
      if (job_wr || cm_wr) begin
        job_q <= job_q + 2'd1;
      end
      if (job_wr && job_q == 2'd0) speed_l_q <= quo_s;
      if (job_wr && job_q == 2'd1) speed_r_q <= quo_s;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kl_q  <= 22'(cfg_i.left_mm_per_rev * dwo_pkg::MsPerSec);
    kr_q  <= 22'(cfg_i.right_mm_per_rev * dwo_pkg::MsPerSec);
    dsp_q <= 30'({14'b0, cfg_i.counts_per_rev} * {16'b0, cfg_i.sample_period_ms});
    if (item_ld) begin
      flag_out_q <= (cmd_i.op == dwo_pkg::OP_TICK) ? (flag_q || close_n) : flag_q;
      diff_l_q   <= tot_l_n - win_l_q;
      diff_r_q   <= tot_r_n - win_r_q;
    end
    if (mul_en) begin
      product_q <= {32'b0, mul_a} * {32'b0, mul_b};
      sign_q    <= mul_x[31];
    end
    if (job_wr && job_q == 2'd2) dist_l_q <= quo_s;
    if (job_wr && job_q == 2'd3) dist_r_q <= quo_s;
    if (cm_wr) begin
      cm_q[job_q] <= cm_s;
    end
    if (out_ld) begin
      result_q.count_left        <= total_l_q;
      result_q.count_right       <= total_r_q;
      result_q.distance_mm_left  <= dist_l_q;
      result_q.distance_mm_right <= dist_r_q;
      result_q.distance_cm_left  <= cm_q[0];
      result_q.distance_cm_right <= cm_q[1];
      result_q.speed_mm_s_left   <= speed_l_q;
      result_q.speed_mm_s_right  <= speed_r_q;
      result_q.speed_cm_s_left   <= cm_q[2];
      result_q.speed_cm_s_right  <= cm_q[3];
      result_q.speed_updated     <= flag_out_q;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = result_q;

endmodule

[rtl/dual_wheel_odometry_core.sv]
// Top level of the dual wheel odometry core: configuration registers and unit wiring
//
// Request words enter through a short queue (push/full) and results leave through a
// one-word output register (empty/pop); exactly one result word follows each request.
// Words are processed one at a time: the back end takes no new request until the result of
// the current one is loaded into the output register. The time per request is set by the
// single shared divider, which yields two quotient bits per cycle; each request runs two
// distance divisions, a closing tick two speed divisions as well, plus four reciprocal
// multiplies for the centimetre values on the shared 32x32 multiplier.
// Configuration writes are always taken (cfg_ready_o is high) and must only be issued
// while no request is outstanding.
module dual_wheel_odometry_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  dwo_pkg::in_word_t              in_i,
  output logic                           empty,
  input  logic                           pop,
  output dwo_pkg::out_word_t             result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dwo_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dwo_pkg::CfgDataW-1:0]   cfg_data_i
);

  dwo_pkg::cfg_t     cfg_q;
  dwo_pkg::cmd_t     cmd;
  dwo_pkg::div_req_t div_req;
  dwo_pkg::div_rsp_t div_rsp;
  logic              cmd_valid, cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_ms   <= dwo_pkg::TickPeriodRst;
      cfg_q.sample_period_ms <= dwo_pkg::SamplePeriodRst;
      cfg_q.left_mm_per_rev  <= dwo_pkg::MmPerRevRst;
      cfg_q.right_mm_per_rev <= dwo_pkg::MmPerRevRst;
      cfg_q.counts_per_rev   <= dwo_pkg::CountsPerRevRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dwo_pkg::CFG_TICK_PERIOD:   cfg_q.tick_period_ms   <= cfg_data_i[9:0];
        dwo_pkg::CFG_SAMPLE_PERIOD: cfg_q.sample_period_ms <= cfg_data_i[13:0];
        dwo_pkg::CFG_LEFT_MM:       cfg_q.left_mm_per_rev  <= cfg_data_i[11:0];
        dwo_pkg::CFG_RIGHT_MM:      cfg_q.right_mm_per_rev <= cfg_data_i[11:0];
        dwo_pkg::CFG_COUNTS:        cfg_q.counts_per_rev   <= cfg_data_i[15:0];
        default:                    cfg_q                  <= cfg_q;
      endcase
    end
  end

  dwo_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  dwo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dwo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule

[rtl/dwo_chk.sv]
// Port-level checker for the odometry core and its bind
`include "dual_wheel_odometry_core_defines.svh"

module dwo_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input dwo_pkg::out_word_t result_o
);

  `DWO_ASSERT(a_result_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(result_o))
  `DWO_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |=> empty && !full)
  `DWO_ASSERT(a_full_needs_push, clk_i, rst_ni, $rose(full) |-> $past(push))

endmodule

bind dual_wheel_odometry_core dwo_chk u_dwo_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

[dv/tb_dual_wheel_odometry_core.sv]
// Self-checking testbench for the dual wheel odometry core
module tb_dual_wheel_odometry_core;
  import dwo_pkg::*;

  localparam logic [1:0] ReqSpare     = 2'd3;
  localparam logic [2:0] CfgSpareIdx  = 3'd7;
  localparam int         PhaseCount   = 8;
  localparam int         PhaseWords   = 150;
  localparam int         CycleLimit   = 1000000;
  localparam int         SettleCycles = 200;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  in_word_t            in_i        = '0;
  logic                empty;
  logic                pop         = 1'b0;
  out_word_t           result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  dual_wheel_odometry_core DUT (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_i,
    .empty,
    .pop,
    .result_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // odometry state as the core should hold it
  cfg_t        odo_cfg;
  logic [31:0] total_l, total_r, win_start_l, win_start_r, speed_l, speed_r;
  logic [15:0] elapsed;
  logic        upd_flag;

  in_word_t    pending_requests[$];
  out_word_t   expected_reports[$];
  int          requests_queued = 0;
  int          requests_taken  = 0;
  int          mismatches      = 0;
  int          cycles          = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;

  function automatic longint trunc_div(longint num, longint dsr);
    return (dsr == 0) ? 64'sd0 : num / dsr;
  endfunction

  function automatic logic [31:0] travel_mm(logic [31:0] total, logic [11:0] mm);
    longint q;
    q = trunc_div(longint'($signed(total)) * longint'(mm), longint'(odo_cfg.counts_per_rev));
    return q[31:0];
  endfunction

  function automatic logic [31:0] window_speed(logic [31:0] diff, logic [11:0] mm);
    longint p;
    longint q;
    p = longint'($signed(diff)) * longint'(mm) * longint'(MsPerSec);
    q = trunc_div(trunc_div(p, longint'(odo_cfg.counts_per_rev)),
                  longint'(odo_cfg.sample_period_ms));
    return q[31:0];
  endfunction

  function automatic logic [15:0] tenths(logic [31:0] v);
    longint q;
    q = longint'($signed(v)) / 10;
    return q[15:0];
  endfunction

  function automatic out_word_t predict_report(in_word_t w);
    out_word_t r;
    logic      flag_now;
    case (w.req_type)
      REQ_TICK: begin
        total_l = total_l - ({{16{w.delta_left[15]}}, w.delta_left} << 2);
        total_r = total_r + {{16{w.delta_right[15]}}, w.delta_right};
        elapsed = elapsed + 16'(odo_cfg.tick_period_ms);
        if (elapsed >= 16'(odo_cfg.sample_period_ms)) begin
          elapsed     = '0;
          speed_l     = window_speed(total_l - win_start_l, odo_cfg.left_mm_per_rev);
          speed_r     = window_speed(total_r - win_start_r, odo_cfg.right_mm_per_rev);
          win_start_l = total_l;
          win_start_r = total_r;
          upd_flag    = 1'b1;
        end
        flag_now = upd_flag;
      end
      REQ_CLEAR: begin
        total_l     = '0;
        total_r     = '0;
        win_start_l = '0;
        win_start_r = '0;
        speed_l     = '0;
        speed_r     = '0;
        elapsed     = '0;
        flag_now    = upd_flag;
      end
      REQ_STATUS: begin
        flag_now = upd_flag;
        upd_flag = 1'b0;
      end
      default: begin
        flag_now = upd_flag;
      end
    endcase
    r.count_left        = total_l;
    r.count_right       = total_r;
    r.distance_mm_left  = travel_mm(total_l, odo_cfg.left_mm_per_rev);
    r.distance_mm_right = travel_mm(total_r, odo_cfg.right_mm_per_rev);
    r.distance_cm_left  = tenths(r.distance_mm_left);
    r.distance_cm_right = tenths(r.distance_mm_right);
    r.speed_mm_s_left   = speed_l;
    r.speed_mm_s_right  = speed_r;
    r.speed_cm_s_left   = tenths(speed_l);
    r.speed_cm_s_right  = tenths(speed_r);
    r.speed_updated     = flag_now;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // driver: hold the word while full, otherwise advance or idle
  always @(posedge clk_i) begin
    if (push && !full) begin
      expected_reports.push_back(predict_report(in_i));
      requests_taken++;
    end
    if (!push || !full) begin
      if (rst_ni && pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_i <= pending_requests.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (pop && !empty) begin
      if (expected_reports.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        exp_w = expected_reports.pop_front();
        check_field("count_left", exp_w.count_left, result_o.count_left);
        check_field("count_right", exp_w.count_right, result_o.count_right);
        check_field("distance_mm_left", exp_w.distance_mm_left, result_o.distance_mm_left);
        check_field("distance_mm_right", exp_w.distance_mm_right,
                    result_o.distance_mm_right);
        check_field("distance_cm_left", exp_w.distance_cm_left, result_o.distance_cm_left);
        check_field("distance_cm_right", exp_w.distance_cm_right,
                    result_o.distance_cm_right);
        check_field("speed_mm_s_left", exp_w.speed_mm_s_left, result_o.speed_mm_s_left);
        check_field("speed_mm_s_right", exp_w.speed_mm_s_right, result_o.speed_mm_s_right);
        check_field("speed_cm_s_left", exp_w.speed_cm_s_left, result_o.speed_cm_s_left);
        check_field("speed_cm_s_right", exp_w.speed_cm_s_right, result_o.speed_cm_s_right);
        check_field("speed_updated", exp_w.speed_updated, result_o.speed_updated);
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_request(logic [1:0] req, logic [15:0] dl, logic [15:0] dr);
    in_word_t w;
    w.req_type    = req;
    w.delta_left  = dl;
    w.delta_right = dr;
    pending_requests.push_back(w);
    requests_queued++;
  endtask

  function automatic logic [15:0] random_delta();
    case ($urandom_range(2))
      0:       return 16'($urandom);
      1:       return 16'(int'($urandom_range(200)) - 100);
      default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  function automatic logic [1:0] random_req();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 78) return REQ_TICK;
    if (pick < 88) return REQ_STATUS;
    if (pick < 94) return REQ_CLEAR;
    return ReqSpare;
  endfunction

  task automatic wait_idle();
    while (requests_taken != requests_queued || expected_reports.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TICK_PERIOD:   odo_cfg.tick_period_ms   = val[9:0];
      CFG_SAMPLE_PERIOD: odo_cfg.sample_period_ms = val[13:0];
      CFG_LEFT_MM:       odo_cfg.left_mm_per_rev  = val[11:0];
      CFG_RIGHT_MM:      odo_cfg.right_mm_per_rev = val[11:0];
      CFG_COUNTS:        odo_cfg.counts_per_rev   = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] tick, logic [15:0] sample, logic [15:0] lmm,
                           logic [15:0] rmm, logic [15:0] counts);
    write_reg(CFG_TICK_PERIOD, tick);
    write_reg(CFG_SAMPLE_PERIOD, sample);
    write_reg(CFG_LEFT_MM, lmm);
    write_reg(CFG_RIGHT_MM, rmm);
    write_reg(CFG_COUNTS, counts);
  endtask

  task automatic configure_phase(int ph);
    int unsigned tick;
    int unsigned span;
    case (ph)
      0: write_all(16'd1000, 16'd1, 16'd4095, 16'd4095, 16'd1);
      1: write_all(16'd1, 16'd3, 16'd1, 16'd1, 16'd65535);
      2: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      3: begin
        write_all(16'd0, 16'd0, 16'd777, 16'd3, 16'd0);
        write_reg(CfgSpareIdx, 16'hA5A5);
      end
      4: write_all(16'd50, 16'd100, 16'd200, 16'd200, 16'd4000);
      default: begin
        tick = $urandom_range(1, 1000);
        span = tick * $urandom_range(1, 6);
        write_all(16'(tick), 16'((span > 10000) ? 10000 : span),
                  16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                  16'($urandom_range(1, 65535)));
      end
    endcase
  endtask

  initial begin
    odo_cfg     = '{tick_period_ms: TickPeriodRst, sample_period_ms: SamplePeriodRst,
                    left_mm_per_rev: MmPerRevRst, right_mm_per_rev: MmPerRevRst,
                    counts_per_rev: CountsPerRevRst};
    total_l     = '0;
    total_r     = '0;
    win_start_l = '0;
    win_start_r = '0;
    speed_l     = '0;
    speed_r     = '0;
    elapsed     = '0;
    upd_flag    = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(REQ_STATUS, 16'h0000, 16'h0000);
    queue_request(REQ_TICK, 16'h0000, 16'h0000);
    queue_request(REQ_TICK, 16'h8000, 16'h7FFF);
    queue_request(REQ_TICK, 16'h7FFF, 16'h8000);
    queue_request(REQ_TICK, 16'hFFFF, 16'h0001);
    queue_request(REQ_STATUS, 16'h5A5A, 16'hA5A5);
    queue_request(REQ_STATUS, 16'hFFFF, 16'hFFFF);
    queue_request(REQ_TICK, 16'h0001, 16'hFFFF);
    queue_request(REQ_TICK, 16'd100, -16'd200);
    queue_request(REQ_CLEAR, 16'd1234, -16'd1234);
    queue_request(REQ_STATUS, 16'h0000, 16'h0000);
    queue_request(REQ_TICK, 16'h8000, 16'h8000);
    queue_request(REQ_TICK, 16'h7FFF, 16'h7FFF);
    queue_request(ReqSpare, 16'hFFFF, 16'hFFFF);
    queue_request(REQ_TICK, 16'h8000, 16'h8000);
    queue_request(ReqSpare, 16'h0000, 16'h0000);
    queue_request(REQ_TICK, 16'h7FFF, 16'h7FFF);
    queue_request(REQ_CLEAR, 16'h0000, 16'h0000);
    queue_request(REQ_STATUS, 16'h0000, 16'h0000);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      configure_phase(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < PhaseWords; i++)
        queue_request(random_req(), random_delta(), random_delta());
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
